@@ rtl/core/ccks_pkg.sv @@
// ----------------------------------------------------------------------------
// Capacitor charge and kick supervisor package
// Shared constants, codes and command/status types for the supervisor.
// ----------------------------------------------------------------------------
package ccks_pkg;

   localparam int PEAK_DEPTH = 5;
   localparam int PWM_PERIOD = 1000;
   localparam int PEAK_IDX_W = (PEAK_DEPTH > 1) ? $clog2(PEAK_DEPTH) : 1;
   localparam int PEAK_CNT_W = $clog2(PEAK_DEPTH + 1);
   localparam int MAX_US = (PWM_PERIOD - 1) * 16;

   localparam logic [2:0] ACT_TICK      = 3'd0;
   localparam logic [2:0] ACT_ADC       = 3'd1;
   localparam logic [2:0] ACT_DONE      = 3'd2;
   localparam logic [2:0] ACT_CHARGE    = 3'd3;
   localparam logic [2:0] ACT_DISCHARGE = 3'd4;
   localparam logic [2:0] ACT_KICK      = 3'd5;

   localparam logic [1:0] PH_IDLE     = 2'd0;
   localparam logic [1:0] PH_CHARGING = 2'd1;
   localparam logic [1:0] PH_CHARGED  = 2'd2;
   localparam logic [1:0] PH_INHIBIT  = 2'd3;

   localparam logic [2:0] REG_MARGIN    = 3'd0;
   localparam logic [2:0] REG_CTIMEOUT  = 3'd1;
   localparam logic [2:0] REG_DWINDOW   = 3'd2;
   localparam logic [2:0] REG_DMINDROP  = 3'd3;
   localparam logic [2:0] REG_KCHECK    = 3'd4;
   localparam logic [2:0] REG_KMINDROP  = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the transaction and run the event
      logic sort_step; // one insertion step of the median sort
      logic sort_init; // copy ring into sort buffer
      logic finish;    // take median from sort buffer
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic needs_sort; // the event recorded a peak
      logic sort_done;  // the sort buffer is in order
   } stat_type;

endpackage

@@ rtl/core/ccks_ctrl.sv @@
// ----------------------------------------------------------------------------
// Supervisor controller
// Sequences one transaction: event, optional median sort, result.
// ----------------------------------------------------------------------------
module ccks_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ccks_pkg::cmd_type cmd,
   input  ccks_pkg::stat_type stat
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_INIT = 4'b0010,
      ST_SORT = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Next state: an event with a new peak runs the sort before its result.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_INIT;
         end
         ST_INIT: begin
            state_in = stat.needs_sort ? ST_SORT : ST_OUT;
         end
         ST_SORT: begin
            if (stat.sort_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_OUT);
   assign cmd.load       = (state_ff == ST_IDLE) && req_valid;
   assign cmd.sort_init  = (state_ff == ST_INIT) && stat.needs_sort;
   assign cmd.sort_step  = (state_ff == ST_SORT) && !stat.sort_done;
   assign cmd.finish     = (state_ff == ST_SORT) && stat.sort_done;

endmodule

@@ rtl/core/ccks_dp.sv @@
// ----------------------------------------------------------------------------
// Supervisor datapath
// Holds the charge state, timestamps, faults, peak ring and median sorter.
// ----------------------------------------------------------------------------
module ccks_dp (
   input  logic              clock,
   input  logic              reset,
   input  ccks_pkg::cmd_type cmd,
   output ccks_pkg::stat_type stat,
   input  logic [2:0]        req_action,
   input  logic [9:0]        req_adc_raw,
   input  logic              req_done_pin,
   input  logic              req_enable,
   input  logic              req_kick_channel,
   input  logic [15:0]       req_duration_us,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data,
   output logic              rsp_charge_enable,
   output logic              rsp_discharge_enable,
   output logic [7:0]        rsp_voltage_v,
   output logic [3:0]        rsp_fault_flags,
   output logic              rsp_fault_status,
   output logic              rsp_done_status,
   output logic [1:0]        rsp_charge_phase,
   output logic              rsp_kick_fire,
   output logic              rsp_kick_select,
   output logic [9:0]        rsp_kick_duty
);

   localparam int IW = ccks_pkg::PEAK_IDX_W;
   localparam int CW = ccks_pkg::PEAK_CNT_W;
   localparam int D  = ccks_pkg::PEAK_DEPTH;

   // Configuration registers.
   logic [7:0]  margin_ff;
   logic [15:0] ctimeout_ff, dwindow_ff, kcheck_ff;
   logic [7:0]  dmindrop_ff;
   logic [6:0]  kmindrop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff   <= 8'd10;
         ctimeout_ff <= 16'd5000;
         dwindow_ff  <= 16'd1000;
         dmindrop_ff <= 8'd5;
         kcheck_ff   <= 16'd50;
         kmindrop_ff <= 7'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            ccks_pkg::REG_MARGIN:   margin_ff   <= csr_data[7:0];
            ccks_pkg::REG_CTIMEOUT: ctimeout_ff <= csr_data;
            ccks_pkg::REG_DWINDOW:  dwindow_ff  <= csr_data;
            ccks_pkg::REG_DMINDROP: dmindrop_ff <= csr_data[7:0];
            ccks_pkg::REG_KCHECK:   kcheck_ff   <= csr_data;
            ccks_pkg::REG_KMINDROP: kmindrop_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // Supervisor state.
   logic [15:0] elapsed_ff, cstart_ff, dstart_ff, kstart_ff;
   logic [1:0]  phase_ff;
   logic [7:0]  dstart_v_ff, kstart_v_ff, vnow_ff, median_ff;
   logic        kpend_ff, ksel_ff, creq_ff, dact_ff, done_ff, cpin_ff;
   logic [3:0]  faults_ff;
   logic [CW-1:0] pcount_ff;
   logic [IW-1:0] pindex_ff;
   logic [7:0]  ring_ff [D];
   logic        fire_ff, fsel_ff, needs_sort_ff;
   logic [9:0]  duty_ff;

   // Sort buffer and insertion sort pointers (one compare-swap per cycle).
   logic [7:0]    buf_ff [D];
   logic [CW-1:0] si_ff, sj_ff;

   // Event arithmetic, all on the captured state.
   logic [37:0] vprod;
   logic [8:0]  vscaled;
   logic [7:0]  vnew;
   logic [15:0] since_c, since_d, since_k;
   logic [7:0]  thr;
   logic [15:0] us_clamp;
   logic [11:0] duty_full;
   logic        cto, dchk, dbad, kchk, kbad;

   // 404/1250 on a 10-bit value as one multiply by 404 * ceil(2^29/1250)
   // and a shift by 29; the rounding error stays below one count for every
   // 10-bit sample, so the quotient is exact.
   assign vprod   = 38'(req_adc_raw) * 38'd173516788;
   assign vscaled = vprod[37:29];
   assign vnew    = vscaled[8] ? 8'hFF : vscaled[7:0];
   assign since_c = elapsed_ff - cstart_ff;
   assign since_d = elapsed_ff - dstart_ff;
   assign since_k = elapsed_ff - kstart_ff;
   assign cto  = (phase_ff == ccks_pkg::PH_CHARGING) && (since_c >= ctimeout_ff);
   assign dchk = dact_ff && (since_d >= dwindow_ff);
   assign dbad = (vnew > dstart_v_ff) || ((dstart_v_ff - vnew) < dmindrop_ff);
   assign kchk = kpend_ff && (since_k >= kcheck_ff);
   assign kbad = ({1'b0, kstart_v_ff} >= {1'b0, kmindrop_ff, 1'b0}) &&
                 ((vnew > kstart_v_ff) || ((kstart_v_ff - vnew) < {1'b0, kmindrop_ff}));
   assign thr  = (median_ff > margin_ff) ? (median_ff - margin_ff) : 8'd0;
   assign us_clamp = (req_duration_us > 16'(ccks_pkg::MAX_US)) ?
                     16'(ccks_pkg::MAX_US) : req_duration_us;
   assign duty_full = us_clamp[15:4] + {11'd0, |us_clamp[3:0]};

   // One event per transaction; the adc checks follow the model's order.
   always_ff @(posedge clock) begin
      logic [1:0] ph;
      logic       cp;
      if (reset) begin
         elapsed_ff <= '0; cstart_ff <= '0; dstart_ff <= '0; kstart_ff <= '0;
         phase_ff <= ccks_pkg::PH_IDLE; dstart_v_ff <= '0; kstart_v_ff <= '0;
         vnow_ff <= '0; median_ff <= '0; kpend_ff <= 1'b0; ksel_ff <= 1'b0;
         creq_ff <= 1'b0; dact_ff <= 1'b0; done_ff <= 1'b0; cpin_ff <= 1'b0;
         faults_ff <= '0; pcount_ff <= '0; pindex_ff <= '0;
         fire_ff <= 1'b0; fsel_ff <= 1'b0; duty_ff <= '0; needs_sort_ff <= 1'b0;
      end else if (cmd.load) begin
         fire_ff <= 1'b0; fsel_ff <= 1'b0; duty_ff <= '0; needs_sort_ff <= 1'b0;
         ph = phase_ff;
         cp = cpin_ff;
         unique case (req_action)
            ccks_pkg::ACT_TICK: elapsed_ff <= elapsed_ff + 16'd10;
            ccks_pkg::ACT_ADC: begin
               vnow_ff <= vnew;
               if (cto) begin
                  cp = 1'b0; ph = ccks_pkg::PH_IDLE;
                  creq_ff <= 1'b0;
               end
               if (dchk) begin
                  if (dbad) dact_ff <= 1'b0;
                  else begin
                     dstart_ff <= elapsed_ff; dstart_v_ff <= vnew;
                  end
               end
               if (kchk) begin
                  kpend_ff <= 1'b0;
                  if (ph == ccks_pkg::PH_INHIBIT) begin
                     cstart_ff <= elapsed_ff; ph = ccks_pkg::PH_CHARGING; cp = 1'b1;
                  end
               end
               faults_ff <= faults_ff | {kchk & kbad & ksel_ff, kchk & kbad & ~ksel_ff,
                                         dchk & dbad, cto};
               if (median_ff != 8'd0) begin
                  done_ff <= (vnew >= thr);
                  if ((vnew < thr) && creq_ff && !cto && ph == ccks_pkg::PH_CHARGED) begin
                     cstart_ff <= elapsed_ff; ph = ccks_pkg::PH_CHARGING; cp = 1'b1;
                  end
               end
            end
            ccks_pkg::ACT_DONE: begin
               if (!req_done_pin) begin
                  ring_ff[pindex_ff] <= vnow_ff;
                  pindex_ff <= (pindex_ff == IW'(D - 1)) ? '0 : pindex_ff + 1'b1;
                  if (pcount_ff != CW'(D)) pcount_ff <= pcount_ff + 1'b1;
                  needs_sort_ff <= 1'b1;
                  ph = ccks_pkg::PH_CHARGED; cp = 1'b0;
               end
            end
            ccks_pkg::ACT_CHARGE: begin
               creq_ff <= req_enable;
               if (req_enable) begin
                  if (ph == ccks_pkg::PH_IDLE) begin
                     cstart_ff <= elapsed_ff; ph = ccks_pkg::PH_CHARGING; cp = 1'b1;
                  end
               end else begin
                  cp = 1'b0; ph = ccks_pkg::PH_IDLE;
               end
            end
            ccks_pkg::ACT_DISCHARGE: begin
               dact_ff <= req_enable;
               if (req_enable) begin
                  dstart_ff <= elapsed_ff; dstart_v_ff <= vnow_ff;
               end
            end
            ccks_pkg::ACT_KICK: begin
               if (duty_full != 12'd0) begin
                  fire_ff <= 1'b1; fsel_ff <= req_kick_channel;
                  duty_ff <= duty_full[9:0];
                  kpend_ff <= 1'b1; ksel_ff <= req_kick_channel;
                  kstart_ff <= elapsed_ff; kstart_v_ff <= vnow_ff;
                  if (ph != ccks_pkg::PH_IDLE) begin
                     ph = ccks_pkg::PH_INHIBIT; cp = 1'b0;
                  end
               end
            end
            default: ;
         endcase
         phase_ff <= ph;
         cpin_ff  <= cp;
      end else if (cmd.finish) begin
         median_ff <= buf_ff[IW'(pcount_ff >> 1)];
      end
   end

   // Insertion sort over the filled ring, one compare-swap a cycle.
   always_ff @(posedge clock) begin
      if (cmd.sort_init) begin
         for (int k = 0; k < D; k++) buf_ff[k] <= ring_ff[k];
         si_ff <= CW'(1);
         sj_ff <= CW'(1);
      end else if (cmd.sort_step) begin
         if (sj_ff != '0 && buf_ff[IW'(sj_ff - 1'b1)] > buf_ff[IW'(sj_ff)]) begin
            buf_ff[IW'(sj_ff)]        <= buf_ff[IW'(sj_ff - 1'b1)];
            buf_ff[IW'(sj_ff - 1'b1)] <= buf_ff[IW'(sj_ff)];
            sj_ff <= sj_ff - 1'b1;
         end else begin
            si_ff <= si_ff + 1'b1;
            sj_ff <= si_ff + 1'b1;
         end
      end
   end

   assign stat.needs_sort = needs_sort_ff;
   assign stat.sort_done  = (si_ff >= pcount_ff);

   assign rsp_charge_enable    = cpin_ff;
   assign rsp_discharge_enable = dact_ff;
   assign rsp_voltage_v        = vnow_ff;
   assign rsp_fault_flags      = faults_ff;
   assign rsp_fault_status     = |faults_ff;
   assign rsp_done_status      = done_ff;
   assign rsp_charge_phase     = phase_ff;
   assign rsp_kick_fire        = fire_ff;
   assign rsp_kick_select      = fsel_ff;
   assign rsp_kick_duty        = duty_ff;

endmodule

@@ rtl/core/capacitor_charge_kick_supervisor.sv @@
// ----------------------------------------------------------------------------
// Capacitor charge and kick supervisor
// Charger phase machine, fault checks, peak median and kick duty for one
// event per transaction.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/stall    | action, adc_raw, pins, duration
//  rsp_    | out       | rsp_valid/stall    | pins, voltage, faults, kick
//  csr_    | in        | csr_valid/ready    | index, 16-bit data
//
// Events pass through the INIT and OUT states; a DONE event with a new peak
// adds the one-step-a-cycle median sort in the SORT state between them.
// Synchronous reset restores every register but the peak ring, sort buffer and sort pointers.
// A stalled result holds the block; the next transaction waits for it.
module capacitor_charge_kick_supervisor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [9:0]  req_adc_raw,
   input  logic        req_done_pin,
   input  logic        req_enable,
   input  logic        req_kick_channel,
   input  logic [15:0] req_duration_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_charge_enable,
   output logic        rsp_discharge_enable,
   output logic [7:0]  rsp_voltage_v,
   output logic [3:0]  rsp_fault_flags,
   output logic        rsp_fault_status,
   output logic        rsp_done_status,
   output logic [1:0]  rsp_charge_phase,
   output logic        rsp_kick_fire,
   output logic        rsp_kick_select,
   output logic [9:0]  rsp_kick_duty,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   ccks_pkg::cmd_type  cmd;
   ccks_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   ccks_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .stat
   );

   ccks_dp u_dp (
      .clock, .reset, .cmd, .stat,
      .req_action, .req_adc_raw, .req_done_pin, .req_enable,
      .req_kick_channel, .req_duration_us,
      .csr_we(csr_valid), .csr_index, .csr_data,
      .rsp_charge_enable, .rsp_discharge_enable, .rsp_voltage_v,
      .rsp_fault_flags, .rsp_fault_status, .rsp_done_status,
      .rsp_charge_phase, .rsp_kick_fire, .rsp_kick_select, .rsp_kick_duty
   );

`ifndef ASSERT_OFF
   // A fired kick always carries a nonzero duty.
   a_fire_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kick_fire |-> rsp_kick_duty != 10'd0)
      else $error("kick fired with zero duty");
   // The charger pin is only driven while charging.
   a_pin_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_charge_enable |-> rsp_charge_phase == ccks_pkg::PH_CHARGING)
      else $error("charge pin without charging phase");
   // An accepted transaction always leads to a result before the next one.
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken during work");
`endif

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Capacitor charge and kick supervisor testbench
// Drives event transactions and register writes into the supervisor, predicts
// every result with a behavioural model of the charger, fault, peak-median
// and kick logic, and checks the results field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Expected result of one event transaction.
typedef struct {
   logic       charge_en;
   logic       discharge_en;
   logic [7:0] volts;
   logic [3:0] flags;
   logic       any_fault;
   logic       done;
   logic [1:0] phase;
   logic       fire;
   logic       sel;
   logic [9:0] duty;
} supervisor_result_type;

// Behavioural model of the supervisor plus the queue of pending results.
class supervisor_scoreboard;
   logic [7:0]  margin_v;
   logic [15:0] timeout_ms;
   logic [15:0] dwindow_ms;
   logic [7:0]  dmin_drop_v;
   logic [15:0] kcheck_ms;
   logic [6:0]  kmin_drop_v;

   logic [15:0] now_ms;
   logic [1:0]  phase;
   logic [15:0] charge_t0;
   logic [7:0]  peaks [ccks_pkg::PEAK_DEPTH];
   int          peak_cnt;
   int          peak_wr;
   logic [7:0]  median_v;
   logic [15:0] dis_t0;
   logic [7:0]  dis_v0;
   logic        kick_wait;
   logic        kick_b;
   logic [15:0] kick_t0;
   logic [7:0]  kick_v0;
   logic [7:0]  volts;
   logic [3:0]  faults;
   logic        charge_req;
   logic        dis_on;
   logic        done;
   logic        charge_pin;

   supervisor_result_type pending[$];
   int errors;

   function new();
      margin_v = 10; timeout_ms = 5000; dwindow_ms = 1000;
      dmin_drop_v = 5; kcheck_ms = 50; kmin_drop_v = 10;
      now_ms = 0; phase = ccks_pkg::PH_IDLE; charge_t0 = 0; peak_cnt = 0; peak_wr = 0;
      median_v = 0; dis_t0 = 0; dis_v0 = 0; kick_wait = 0; kick_b = 0;
      kick_t0 = 0; kick_v0 = 0; volts = 0; faults = 0; charge_req = 0;
      dis_on = 0; done = 0; charge_pin = 0; errors = 0;
      foreach (peaks[i]) peaks[i] = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
         ccks_pkg::REG_MARGIN:   margin_v = data[7:0];
         ccks_pkg::REG_CTIMEOUT: timeout_ms = data;
         ccks_pkg::REG_DWINDOW:  dwindow_ms = data;
         ccks_pkg::REG_DMINDROP: dmin_drop_v = data[7:0];
         ccks_pkg::REG_KCHECK:   kcheck_ms = data;
         ccks_pkg::REG_KMINDROP: kmin_drop_v = data[6:0];
         default: ;
      endcase
   endfunction

   function logic [15:0] age(logic [15:0] t0);
      return now_ms - t0;
   endfunction

   function void begin_charge();
      charge_t0 = now_ms;
      phase = ccks_pkg::PH_CHARGING;
      charge_pin = 1;
   endfunction

   function void add_peak(logic [7:0] v);
      logic [7:0] buf_s [ccks_pkg::PEAK_DEPTH];
      logic [7:0] key;
      int j;
      peaks[peak_wr] = v;
      peak_wr = (peak_wr + 1) % ccks_pkg::PEAK_DEPTH;
      if (peak_cnt < ccks_pkg::PEAK_DEPTH) peak_cnt++;
      for (int i = 0; i < peak_cnt; i++) buf_s[i] = peaks[i];
      for (int i = 1; i < peak_cnt; i++) begin
         key = buf_s[i];
         j = i;
         while (j > 0 && buf_s[j-1] > key) begin
            buf_s[j] = buf_s[j-1];
            j--;
         end
         buf_s[j] = key;
      end
      median_v = buf_s[peak_cnt / 2];
   endfunction

   function void sample(logic [9:0] raw);
      int unsigned v;
      int unsigned thr;
      v = raw * 404 / 1250;
      volts = (v > 255) ? 8'd255 : v[7:0];
      // Charge timeout
      if (phase == ccks_pkg::PH_CHARGING && age(charge_t0) >= timeout_ms) begin
         charge_pin = 0;
         phase = ccks_pkg::PH_IDLE;
         charge_req = 0;
         faults[0] = 1;
      end
      // Discharge progress
      if (dis_on && age(dis_t0) >= dwindow_ms) begin
         if (volts > dis_v0 || (dis_v0 - volts) < dmin_drop_v) begin
            dis_on = 0;
            faults[1] = 1;
         end else begin
            dis_t0 = now_ms;
            dis_v0 = volts;
         end
      end
      // Drop check after a kick, then charging resumes
      if (kick_wait && age(kick_t0) >= kcheck_ms) begin
         kick_wait = 0;
         if (kick_v0 >= 2 * kmin_drop_v &&
             (volts > kick_v0 || (kick_v0 - volts) < kmin_drop_v)) begin
            if (kick_b) faults[3] = 1;
            else faults[2] = 1;
         end
         if (phase == ccks_pkg::PH_INHIBIT) begin_charge();
      end
      // Recharge threshold from the median peak
      if (median_v > 0) begin
         thr = (median_v > margin_v) ? median_v - margin_v : 0;
         done = (volts >= thr);
         if (!done && charge_req && phase == ccks_pkg::PH_CHARGED) begin_charge();
      end
   endfunction

   // Notes an accepted event and queues the result that it should produce.
   function void note_event(logic [2:0] act, logic [9:0] raw, logic pin, logic en,
                            logic chan, logic [15:0] dur);
      supervisor_result_type r;
      int unsigned us;
      int unsigned duty;
      logic fire;
      fire = 0;
      duty = 0;
      case (act)
         ccks_pkg::ACT_TICK: now_ms = now_ms + 16'd10;
         ccks_pkg::ACT_ADC:  sample(raw);
         ccks_pkg::ACT_DONE: if (!pin) begin
            add_peak(volts);
            phase = ccks_pkg::PH_CHARGED;
            charge_pin = 0;
         end
         ccks_pkg::ACT_CHARGE: begin
            charge_req = en;
            if (en) begin
               if (phase == ccks_pkg::PH_IDLE) begin_charge();
            end else begin
               charge_pin = 0;
               phase = ccks_pkg::PH_IDLE;
            end
         end
         ccks_pkg::ACT_DISCHARGE: begin
            dis_on = en;
            if (en) begin
               dis_t0 = now_ms;
               dis_v0 = volts;
            end
         end
         ccks_pkg::ACT_KICK: begin
            us = (dur > ccks_pkg::MAX_US) ? ccks_pkg::MAX_US : dur;
            duty = (us + 15) / 16;
            if (duty != 0) begin
               fire = 1;
               kick_wait = 1;
               kick_b = chan;
               kick_t0 = now_ms;
               kick_v0 = volts;
               if (phase != ccks_pkg::PH_IDLE) begin
                  phase = ccks_pkg::PH_INHIBIT;
                  charge_pin = 0;
               end
            end
         end
         default: ;
      endcase
      r.charge_en = charge_pin;
      r.discharge_en = dis_on;
      r.volts = volts;
      r.flags = faults;
      r.any_fault = (faults != 0);
      r.done = done;
      r.phase = phase;
      r.fire = fire;
      r.sel = fire ? chan : 1'b0;
      r.duty = fire ? duty[9:0] : 10'd0;
      pending.push_back(r);
   endfunction

   function void report(string field, int exp_v, int act_v);
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, field, exp_v, act_v);
      errors++;
   endfunction

   // Checks one accepted result against the oldest expectation.
   function void check_result(supervisor_result_type got);
      supervisor_result_type e;
      if (pending.size() == 0) begin
         $display("%0t: result with no event outstanding", $time);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (got.charge_en !== e.charge_en) report("charge_enable", e.charge_en, got.charge_en);
      if (got.discharge_en !== e.discharge_en)
         report("discharge_enable", e.discharge_en, got.discharge_en);
      if (got.volts !== e.volts) report("voltage_v", e.volts, got.volts);
      if (got.flags !== e.flags) report("fault_flags", e.flags, got.flags);
      if (got.any_fault !== e.any_fault) report("fault_status", e.any_fault, got.any_fault);
      if (got.done !== e.done) report("done_status", e.done, got.done);
      if (got.phase !== e.phase) report("charge_phase", e.phase, got.phase);
      if (got.fire !== e.fire) report("kick_fire", e.fire, got.fire);
      if (got.sel !== e.sel) report("kick_select", e.sel, got.sel);
      if (got.duty !== e.duty) report("kick_duty", e.duty, got.duty);
   endfunction
endclass

module testbench;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_action = ccks_pkg::ACT_TICK;
   logic [9:0]  req_adc_raw = 0;
   logic        req_done_pin = 1;
   logic        req_enable = 0;
   logic        req_kick_channel = 0;
   logic [15:0] req_duration_us = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_charge_enable;
   logic        rsp_discharge_enable;
   logic [7:0]  rsp_voltage_v;
   logic [3:0]  rsp_fault_flags;
   logic        rsp_fault_status;
   logic        rsp_done_status;
   logic [1:0]  rsp_charge_phase;
   logic        rsp_kick_fire;
   logic        rsp_kick_select;
   logic [9:0]  rsp_kick_duty;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = ccks_pkg::REG_MARGIN;
   logic [15:0] csr_data = 0;

   supervisor_scoreboard board = new();
   int unsigned cycles = 0;
   int          n_sent = 0;
   logic        stall_storm = 0;

   capacitor_charge_kick_supervisor u_top (.*);

   always #5 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side: random stalls and checking of every accepted transaction.
   always @(posedge clock) begin
      supervisor_result_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.charge_en = rsp_charge_enable;
            got.discharge_en = rsp_discharge_enable;
            got.volts = rsp_voltage_v;
            got.flags = rsp_fault_flags;
            got.any_fault = rsp_fault_status;
            got.done = rsp_done_status;
            got.phase = rsp_charge_phase;
            got.fire = rsp_kick_fire;
            got.sel = rsp_kick_select;
            got.duty = rsp_kick_duty;
            board.check_result(got);
         end
         if (!stall_storm) rsp_stall <= 0;
         else if ($urandom_range(99) < 3) rsp_stall <= ($urandom_range(99) < 50);
         else rsp_stall <= ($urandom_range(99) < 30);
      end
   end

   // Mostly short gaps, occasionally a long one.
   task automatic idle_gap();
      int n;
      n = ($urandom_range(99) < 6) ? $urandom_range(40, 10) : $urandom_range(2);
      repeat (n) @(posedge clock);
   endtask

   // Sends one event and waits for it to be accepted.
   task automatic send_event(logic [2:0] act, logic [9:0] raw, logic pin, logic en,
                             logic chan, logic [15:0] dur);
      req_valid <= 1;
      req_action <= act;
      req_adc_raw <= raw;
      req_done_pin <= pin;
      req_enable <= en;
      req_kick_channel <= chan;
      req_duration_us <= dur;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_event(act, raw, pin, en, chan, dur);
      n_sent++;
      req_valid <= 0;
      // The block is busy for the cycle after an accepted transaction.
      @(posedge clock);
      if (stall_storm) idle_gap();
   endtask

   task automatic send_rand(logic [2:0] act);
      send_event(act, 10'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                 16'($urandom));
   endtask

   // Waits until every result has arrived and the block has settled.
   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, data);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // Charge, sample, DONE, kick and recovery with random content.
   task automatic charge_cycle();
      int hi;
      hi = $urandom_range(1023, 300);
      send_event(ccks_pkg::ACT_CHARGE, 0, 1, 1, 0, 0);
      repeat ($urandom_range(4)) send_event(ccks_pkg::ACT_TICK, 0, 1, 0, 0, 0);
      send_event(ccks_pkg::ACT_ADC, 10'(hi), 1, 0, 0, 0);
      send_event(ccks_pkg::ACT_DONE, 0, 0, 0, 0, 0);
      if ($urandom_range(1)) send_event(ccks_pkg::ACT_DISCHARGE, 0, 1, 1, 0, 0);
      send_event(ccks_pkg::ACT_KICK, 0, 1, 0, 1'($urandom), 16'($urandom_range(20000)));
      repeat ($urandom_range(8, 1)) begin
         send_event(ccks_pkg::ACT_TICK, 0, 1, 0, 0, 0);
         send_event(ccks_pkg::ACT_ADC, 10'($urandom_range(hi)), 1, 0, 0, 0);
      end
      if ($urandom_range(3) == 0) send_event(ccks_pkg::ACT_CHARGE, 0, 1, 0, 0, 0);
   endtask

   task automatic random_phase(int count);
      int start;
      start = n_sent;
      while (n_sent - start < count) begin
         if ($urandom_range(99) < 55) begin
            charge_cycle();
         end else begin
            send_rand(3'($urandom_range(7)));
         end
      end
   endtask

   initial begin
      logic [15:0] reg_set [6];
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes of the fields and the special cases.
      send_event(ccks_pkg::ACT_ADC, 10'd1023, 1, 0, 0, 0);      // saturates at 255
      send_event(ccks_pkg::ACT_DONE, 0, 1, 0, 0, 0);            // DONE high does nothing
      send_event(ccks_pkg::ACT_DONE, 0, 0, 0, 0, 0);            // peak from idle
      send_event(ccks_pkg::ACT_ADC, 10'd0, 1, 0, 0, 0);
      send_event(ccks_pkg::ACT_CHARGE, 0, 1, 1, 0, 0);
      send_event(ccks_pkg::ACT_ADC, 10'd500, 1, 0, 0, 0);
      send_event(ccks_pkg::ACT_KICK, 0, 1, 0, 0, 16'd0);        // zero duty does nothing
      send_event(ccks_pkg::ACT_KICK, 0, 1, 0, 1, 16'd1);
      send_event(ccks_pkg::ACT_KICK, 0, 1, 0, 0, 16'd17);
      send_event(ccks_pkg::ACT_KICK, 0, 1, 0, 1, 16'hFFFF);     // clamps at 999
      send_event(ccks_pkg::ACT_DISCHARGE, 0, 1, 1, 0, 0);
      send_event(ccks_pkg::ACT_DISCHARGE, 0, 1, 0, 0, 0);
      send_event(3'd6, 10'h3FF, 0, 1, 1, 16'hFFFF);             // unused actions
      send_event(3'd7, 10'h155, 1, 0, 0, 16'h5555);
      send_event(ccks_pkg::ACT_CHARGE, 0, 1, 0, 0, 0);
      repeat (6) send_event(ccks_pkg::ACT_TICK, 0, 1, 0, 0, 0);
      send_event(ccks_pkg::ACT_ADC, 10'd700, 1, 0, 0, 0);
      drain();

      // Several register settings, extremes among them, with random traffic.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: reg_set = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            1: reg_set = '{16'd255, 16'hFFFF, 16'hFFFF, 16'd255, 16'hFFFF, 16'd127};
            default: reg_set = '{16'($urandom_range(30)), 16'($urandom_range(200)),
                                 16'($urandom_range(100)), 16'($urandom_range(20)),
                                 16'($urandom_range(60)), 16'($urandom_range(40))};
         endcase
         for (int r = 0; r < 6; r++) write_reg(3'(r), reg_set[r]);
         stall_storm <= (ph != 2);
         random_phase(105);
         // Hold off until every outstanding result is back.
         drain();
      end

      drain();
      if (board.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
